// ===== hdl/round_robin_completion_times_core_assert.svh =====
// Assertion helpers for the round-robin completion times block
`ifndef ROUND_ROBIN_COMPLETION_TIMES_CORE_ASSERT_SVH
`define ROUND_ROBIN_COMPLETION_TIMES_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define RRCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define RRCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rrct_pkg.sv =====
package rrct_pkg;

    localparam int BURST_W = 16;
    localparam int CLOCK_W = 20;
    localparam int IDX_W   = 4;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

    typedef logic [BURST_W-1:0] burst_t;
    typedef logic [CLOCK_W-1:0] clock_t;
    typedef logic [IDX_W-1:0]   job_idx_t;

endpackage

// ===== hdl/round_robin_completion_times_core.sv =====
// Loading: one cycle per request, in_ready high while collecting a set.
// Run: one cycle per turn of the shared slice/subtract unit, finished jobs included;
// the run visits the jobs round-robin until every job is done.
// Results: one per cycle at full out_ready, in load order; the output register
// lets the next set start loading while the final result still waits.
// Reset (async, rst_n low): set empty, quantum 2, job stores undefined until loaded.
`include "round_robin_completion_times_core_assert.svh"

module round_robin_completion_times_core #(
    parameter int MAX_JOBS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  rrct_pkg::burst_t  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  rrct_pkg::burst_t  burst,
    input  logic              last_job,
    output logic              out_valid,
    input  logic              out_ready,
    output rrct_pkg::job_idx_t job_index,
    output rrct_pkg::clock_t  wait_time,
    output rrct_pkg::clock_t  turnaround,
    output logic              last_result
);
    import rrct_pkg::*;

    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    burst_t             quantum_reg, quantum_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      left_reg, left_next;
    logic [IW-1:0]      ptr_reg, ptr_next;
    logic [IW-1:0]      oidx_reg, oidx_next;
    clock_t             clock_reg, clock_next;
    logic [MAX_JOBS-1:0] done_reg, done_next;
    logic               out_valid_reg, out_valid_next;
    job_idx_t           job_index_reg, job_index_next;
    clock_t             wait_reg, wait_next;
    clock_t             turn_reg, turn_next;
    logic               last_reg, last_next;

    burst_t burst_mem [MAX_JOBS];
    burst_t rem_mem   [MAX_JOBS];
    clock_t fin_mem   [MAX_JOBS];

    burst_t            rem_rd_reg;
    clock_t            fin_rd_reg;
    burst_t            burst_rd_reg;

    logic              in_fire;
    logic              has_room;
    logic [CW-1:0]     count_inc;
    burst_t            q_eff;
    burst_t            rem_cur;
    burst_t            slice;
    burst_t            rem_new;
    logic [CLOCK_W:0]  clock_sum;
    clock_t            clock_new;
    logic              turn_active;
    logic              turn_finish;
    logic              out_load;
    logic              out_is_last;
    clock_t            fin_cur;
    logic              rem_we;
    logic [IW-1:0]     rem_waddr;
    burst_t            rem_wdata;
    logic              fin_we;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign has_room  = (count_reg < CW'(MAX_JOBS));
    assign count_inc = has_room ? count_reg + CW'(1) : count_reg;

    // shared slice unit: min, subtract, saturating add
    assign q_eff       = (quantum_reg == '0) ? BURST_W'(1) : quantum_reg;
    assign rem_cur     = rem_rd_reg;
    assign slice       = (rem_cur < q_eff) ? rem_cur : q_eff;
    assign rem_new     = rem_cur - slice;
    assign clock_sum   = {1'b0, clock_reg} + (CLOCK_W + 1)'(slice);
    assign clock_new   = clock_sum[CLOCK_W] ? CLOCK_MAX : clock_sum[CLOCK_W-1:0];
    assign turn_active = (state_reg == ST_RUN) && !done_reg[ptr_reg];
    assign turn_finish = turn_active && (rem_new == '0);

    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign out_is_last = (CW'(oidx_reg) + CW'(1) == count_reg);
    assign fin_cur     = fin_rd_reg;

    assign rem_we    = (in_fire && has_room) || turn_active;
    assign rem_waddr = turn_active ? ptr_reg : count_reg[IW-1:0];
    assign rem_wdata = turn_active ? rem_new : burst;
    assign fin_we    = turn_finish;

    always_comb
    begin
        state_next     = state_reg;
        quantum_next   = quantum_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        ptr_next       = ptr_reg;
        oidx_next      = oidx_reg;
        clock_next     = clock_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        job_index_next = job_index_reg;
        wait_next      = wait_reg;
        turn_next      = turn_reg;
        last_next      = last_reg;

        if (cfg_valid)
        begin
            quantum_next = cfg_data;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    count_next = count_inc;
                    if (has_room)
                    begin
                        done_next[count_reg[IW-1:0]] = 1'b0;
                    end
                    if (last_job)
                    begin
                        state_next = ST_RUN;
                        left_next  = count_inc;
                        ptr_next   = '0;
                        clock_next = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (turn_active)
                begin
                    clock_next = clock_new;
                end
                if (turn_finish)
                begin
                    done_next[ptr_reg] = 1'b1;
                    left_next          = left_reg - CW'(1);
                end
                ptr_next = (CW'(ptr_reg) + CW'(1) < count_reg) ? ptr_reg + IW'(1) : '0;
                if (turn_finish && left_reg == CW'(1))
                begin
                    state_next = ST_OUT;
                    oidx_next  = '0;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    job_index_next = IDX_W'(oidx_reg);
                    turn_next      = fin_cur;
                    wait_next      = fin_cur - CLOCK_W'(burst_rd_reg);
                    last_next      = out_is_last;
                    if (out_is_last)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        clock_next = '0;
                        ptr_next   = '0;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            quantum_reg   <= BURST_W'(2);
            count_reg     <= '0;
            left_reg      <= '0;
            ptr_reg       <= '0;
            oidx_reg      <= '0;
            clock_reg     <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
            job_index_reg <= '0;
            wait_reg      <= '0;
            turn_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quantum_reg   <= quantum_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            ptr_reg       <= ptr_next;
            oidx_reg      <= oidx_next;
            clock_reg     <= clock_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            job_index_reg <= job_index_next;
            wait_reg      <= wait_next;
            turn_reg      <= turn_next;
            last_reg      <= last_next;
        end
    end

    // job stores, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire && has_room)
        begin
            burst_mem[count_reg[IW-1:0]] <= burst;
        end
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (fin_we)
        begin
            fin_mem[ptr_reg] <= clock_new;
        end
        // read ahead at next cycle's address, same-cycle remaining/finish write data passed through
        rem_rd_reg   <= (rem_we && rem_waddr == ptr_next) ? rem_wdata : rem_mem[ptr_next];
        fin_rd_reg   <= (fin_we && ptr_reg == oidx_next) ? clock_new : fin_mem[oidx_next];
        burst_rd_reg <= burst_mem[oidx_next];
    end

    assign out_valid   = out_valid_reg;
    assign job_index   = job_index_reg;
    assign wait_time   = wait_reg;
    assign turnaround  = turn_reg;
    assign last_result = last_reg;

    `RRCT_ASSERT_NOW(a_left_bounded, state_reg == ST_RUN, left_reg != '0 && left_reg <= count_reg,
        "unfinished job count out of range during run")
    `RRCT_ASSERT_NOW(a_set_not_empty, state_reg != ST_LOAD, count_reg != '0,
        "run or report with an empty job set")
    `RRCT_ASSERT_NEXT(a_clock_monotone, state_reg == ST_RUN && state_next == ST_RUN,
        clock_reg >= $past(clock_reg), "simulated clock went backwards")
    `RRCT_ASSERT_NEXT(a_report_ends, out_load && out_is_last,
        state_reg == ST_LOAD && count_reg == '0 && out_valid_reg && last_reg,
        "final result did not close the set")

endmodule
